// ----- hdl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

    // Field widths
    localparam int DataW   = 32;
    localparam int OpW     = 2;
    localparam int StatW   = 2;
    localparam int OccW    = 5;
    localparam int InDataW  = 32;
    localparam int OutDataW = 40;

    // Default number of cells
    localparam int DefaultCapacity = 16;

    // Opcodes
    localparam logic [OpW-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OpW-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OpW-1:0] OP_PEEK    = 2'd2;

    // Status codes
    localparam logic [StatW-1:0] ST_OK    = 2'd0;
    localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StatW-1:0] ST_FULL  = 2'd2;

    localparam logic signed [DataW-1:0] EmptyValue = -32'sd1;

    // Control broadcast to every cell
    typedef struct packed {
        logic                    insert;
        logic                    remove;
        logic signed [DataW-1:0] value;
    } t_spq_ctl;

endpackage
`default_nettype wire

// ----- hdl/spq_cell.sv -----
`default_nettype none
module spq_cell #(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  wire                             i_clk,
    input  wire [CW-1:0]                    i_count,
    input  spq_pkg::t_spq_ctl               i_ctl,
    input  wire signed [spq_pkg::DataW-1:0] i_prev_val,
    input  wire                             i_prev_lt,
    input  wire signed [spq_pkg::DataW-1:0] i_next_val,
    output logic signed [spq_pkg::DataW-1:0] o_val,
    output logic                            o_lt
);
    import spq_pkg::*;

    logic signed [DataW-1:0] r_val;
    logic signed [DataW-1:0] n_val;
    logic                    w_occ;

    // Flag an occupied entry that sorts strictly before the new value
    assign w_occ = (CW'(INDEX) < i_count);
    assign o_lt  = w_occ && (r_val < i_ctl.value);
    assign o_val = r_val;

    // Keep, take the new value, shift up from the left, or shift down from the right
    always_comb begin
        n_val = r_val;
        if (i_ctl.insert) begin
            if (!o_lt) begin
                if (i_prev_lt) begin
                    n_val = i_ctl.value;
                end else begin
                    n_val = i_prev_val;
                end
            end
        end else if (i_ctl.remove) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
// Sorted min-priority queue built as a chain of compare-and-shift cells.
// Result is registered to the master side in the cycle after the input transaction.
// Throughput: one transaction per cycle while input ready holds; every cell compares
// and shifts in parallel. Ready drops only while a result waits and master is stalled.
// Reset (synchronous, active low) clears the entry count and the output valid;
// cell contents are left as they are and are never read before being written.
`default_nettype none
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DefaultCapacity
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [spq_pkg::InDataW-1:0]       s_axis_tdata,  // [31:0] value
    input  wire [spq_pkg::OpW-1:0]           s_axis_tuser,  // [1:0] opcode
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [31:0] result_value, [32] now_empty, [37:33] occupancy, [39:38] zero
    output logic [spq_pkg::OutDataW-1:0]     m_axis_tdata,
    output logic [spq_pkg::StatW-1:0]        m_axis_tuser   // [1:0] status
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic [OpW-1:0]          w_op;
    t_spq_ctl                w_ctl;
    logic signed [DataW-1:0] w_val [CAPACITY];
    logic                    w_lt  [CAPACITY];

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    logic signed [DataW-1:0] r_res;
    logic signed [DataW-1:0] n_res;
    logic [StatW-1:0]        r_stat;
    logic [StatW-1:0]        n_stat;
    logic [CW+OccW-1:0]      w_cnt_ext;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_full        = (r_count == CW'(CAPACITY));
    assign w_empty       = (r_count == '0);

    // Decode the operation into cell control
    always_comb begin
        w_ctl.insert = w_accept && (w_op == OP_ENQUEUE) && !w_full;
        w_ctl.remove = w_accept && (w_op == OP_DEQUEUE) && !w_empty;
        w_ctl.value  = s_axis_tdata[DataW-1:0];
    end

    // Chain of cells, smallest at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DataW-1:0] w_prev_val;
        logic                    w_prev_lt;
        logic signed [DataW-1:0] w_next_val;
        if (g == 0) begin : g_first
            assign w_prev_val = w_val[g];
            assign w_prev_lt  = 1'b1;
        end else begin : g_mid
            assign w_prev_val = w_val[g-1];
            assign w_prev_lt  = w_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next_val = w_val[g];
        end else begin : g_inner
            assign w_next_val = w_val[g+1];
        end
        spq_cell #(
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_count    (r_count),
            .i_ctl      (w_ctl),
            .i_prev_val (w_prev_val),
            .i_prev_lt  (w_prev_lt),
            .i_next_val (w_next_val),
            .o_val      (w_val[g]),
            .o_lt       (w_lt[g])
        );
    end

    // Form the result and the next count
    always_comb begin
        n_count = r_count;
        n_res   = '0;
        n_stat  = ST_OK;
        case (w_op)
            OP_ENQUEUE: begin
                if (w_full) begin
                    n_stat = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (w_empty) begin
                    n_res  = EmptyValue;
                    n_stat = ST_EMPTY;
                end else begin
                    n_res = w_val[0];
                    if (w_op == OP_DEQUEUE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Hold the count and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res  <= n_res;
            r_stat <= n_stat;
        end
    end

    assign w_cnt_ext     = {{OccW{1'b0}}, r_count};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_stat;
    assign m_axis_tdata  = {2'b00, w_cnt_ext[OccW-1:0], (r_count == '0), r_res};

endmodule
`default_nettype wire

// ----- hdl/spq_checker.sv -----
`default_nettype none
module spq_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [spq_pkg::OutDataW-1:0]  m_axis_tdata,
    input wire [spq_pkg::StatW-1:0]     m_axis_tuser
);
    import spq_pkg::*;

    // Stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // Empty status returns the empty marker on an empty queue
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |->
            ((m_axis_tdata[DataW-1:0] == EmptyValue) && m_axis_tdata[DataW]))
        else $error("empty status with wrong payload");

    // Dropped insert returns zero from a non-empty queue
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |->
            ((m_axis_tdata[DataW-1:0] == '0) && !m_axis_tdata[DataW]))
        else $error("full status with wrong payload");

    // Empty flag agrees with occupancy
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[DataW]) |->
            (m_axis_tdata[DataW+OccW:DataW+1] == '0))
        else $error("empty flag with nonzero occupancy");

    // Reset drops any pending result
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
